// ===== rtl/dqidct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqidct_pkg
// Shared types, constants and the cosine table for the dequantizing 8x8 IDCT.
// ----------------------------------------------------------------------------
package dqidct_pkg;

	localparam int BLOCK_SIZE = 8;
	localparam int NCOEF      = BLOCK_SIZE * BLOCK_SIZE;
	localparam int TAP_W      = $clog2(BLOCK_SIZE);
	localparam int ELEM_W     = $clog2(NCOEF);
	localparam int ISSUE_W    = 1 + ELEM_W + TAP_W;

	localparam int LEVEL_W  = 12;
	localparam int QUANT_W  = 7;
	localparam int DQ_W     = LEVEL_W + QUANT_W;
	localparam int ROW_W    = 32;
	localparam int SAMPLE_W = 16;
	localparam int ROW_FRAC = 8;

	localparam logic [ELEM_W-1:0] ELEM_LAST = ELEM_W'(NCOEF - 1);
	localparam logic [TAP_W-1:0]  TAP_LAST  = TAP_W'(BLOCK_SIZE - 1);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef enum logic {
		PASS_ROW,
		PASS_COL
	} pass_t;

	// Control that travels with one multiply-accumulate tap.
	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		pass_t             pass;
		logic [ELEM_W-1:0] elem;
	} tap_ctrl_t;

	// Luminance quantization table, row-major.
	localparam logic [QUANT_W-1:0] LUM_QUANT [NCOEF] = '{
		7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
		7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
		7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
		7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
		7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
		7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
		7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
		7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
	};

	// 0.5*cos(k*pi/16) in Q1.30, k = 0..8.
	localparam int HALF_COS_Q30 [9] = '{
		536870912, 526555088, 496004047, 446391849, 379625062,
		298269498, 205451603, 104738319, 0
	};

	// DCT basis entry T[u][x] rounded to frac fractional bits.
	function automatic int cos_q(input logic [TAP_W-1:0] u, input logic [TAP_W-1:0] x,
			input int frac);
		logic [4:0] a;
		logic       neg;
		int         mag;
		neg = 1'b0;
		if (u == '0) begin
			a = 5'd4;
		end else begin
			a = 5'(8'(u) * 8'({x, 1'b1}));
			if (a > 5'd16) begin
				a = 5'(6'd32 - 6'(a));
			end
			if (a > 5'd8) begin
				a = 5'(5'd16 - a);
				neg = 1'b1;
			end
		end
		mag = (HALF_COS_Q30[a[3:0]] + (1 << (29 - frac))) >>> (30 - frac);
		return neg ? -mag : mag;
	endfunction

endpackage

// ===== rtl/dqidct_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqidct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dqidct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/dqidct_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqidct_mac
// Shared multiply-accumulate unit with rounding for both transform passes.
// ----------------------------------------------------------------------------
module dqidct_mac
	import dqidct_pkg::*;
#(
	parameter int COS_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  tap_ctrl_t                     ctl_s1,
	input  logic signed [ROW_W-1:0]       a_s1,
	input  logic signed [COS_FRAC_BITS:0] c_s1,
	output tap_ctrl_t                     done,
	output logic                          busy,
	output logic [ROW_W-1:0]              row_val,
	output logic [SAMPLE_W-1:0]           col_val
);

	localparam int C_W       = COS_FRAC_BITS + 1;
	localparam int P_W       = ROW_W + C_W;
	localparam int ACC_W     = P_W + TAP_W;
	localparam int ROW_SHIFT = COS_FRAC_BITS - ROW_FRAC;
	localparam int COL_SHIFT = COS_FRAC_BITS + ROW_FRAC - 2;

	localparam logic signed [ACC_W-1:0] ROW_HALF = ACC_W'(1) << (ROW_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] COL_HALF = ACC_W'(1) << (COL_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN  = ~SAT_MAX;

	tap_ctrl_t               ctl_s2;
	tap_ctrl_t               done_d;
	logic signed [P_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] row_sum;
	logic signed [ACC_W-1:0] row_sh;
	logic signed [ACC_W-1:0] col_sum;
	logic signed [ACC_W-1:0] col_sh;

	// A sum is complete only once its last tap has been accumulated.
	always_comb begin
		done_d       = ctl_s2;
		done_d.valid = ctl_s2.valid & ctl_s2.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done   <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
			done   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= P_W'(a_s1) * P_W'(c_s1);
			if (ctl_s2.valid) begin
				acc_q <= ctl_s2.first ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// Round half up; rows keep 8 fractional bits, columns saturate to int16.
	always_comb begin
		row_sum = acc_q + ROW_HALF;
		row_sh  = row_sum >>> ROW_SHIFT;
		row_val = row_sh[ROW_W-1:0];
		col_sum = acc_q + COL_HALF;
		col_sh  = col_sum >>> COL_SHIFT;
		if (col_sh > SAT_MAX) begin
			col_val = SAT_MAX[SAMPLE_W-1:0];
		end else if (col_sh < SAT_MIN) begin
			col_val = SAT_MIN[SAMPLE_W-1:0];
		end else begin
			col_val = col_sh[SAMPLE_W-1:0];
		end
	end

	assign busy = ctl_s2.valid | done.valid;

endmodule

// ===== rtl/dequantize_inverse_dct_8x8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dequantize_inverse_dct_8x8
// Dequantizes one 8x8 block of levels and applies the scaled inverse DCT.
// ----------------------------------------------------------------------------
// The block takes 64 levels in row-major order, one per cycle, scaling each by
// the luminance quantization table as it is written to the coefficient RAM.
// After the 64th level it stops taking requests and runs a row pass and a
// column pass through one shared multiplier-accumulator, one product per
// cycle while out_stall does not hold the output: 1024 products, then the
// pipeline drains. The 64 samples leave during the column pass through an
// output register, the last one flagged.
module dequantize_inverse_dct_8x8
	import dqidct_pkg::*;
#(
	parameter int COS_FRAC_BITS = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [LEVEL_W-1:0]  level,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic                       last_of_block
);

	localparam int C_W = COS_FRAC_BITS + 1;

	state_t               state_q;
	state_t               state_d;
	logic [ELEM_W-1:0]    in_cnt_q;
	logic [ISSUE_W-1:0]   iss_cnt_q;
	logic                 in_acc;
	logic                 adv;
	logic                 mac_busy;

	tap_ctrl_t            iss_ctl;
	logic [TAP_W-1:0]     iss_tap;
	logic [TAP_W-1:0]     cos_u;
	logic [TAP_W-1:0]     cos_x;
	tap_ctrl_t            ctl_s1;
	logic signed [C_W-1:0] cos_s1;
	logic signed [ROW_W-1:0] a_s1;

	logic signed [DQ_W-1:0] dq;
	logic                 coef_re;
	logic [ELEM_W-1:0]    coef_raddr;
	logic [DQ_W-1:0]      coef_rd;
	logic                 row_re;
	logic                 row_we;
	logic [ELEM_W-1:0]    row_raddr;
	logic [ROW_W-1:0]     row_rd;

	tap_ctrl_t            done;
	logic [ROW_W-1:0]     row_val;
	logic [SAMPLE_W-1:0]  col_val;
	logic                 out_load;

	assign in_stall = (state_q != ST_LOAD);
	assign in_acc   = in_valid & ~in_stall;
	// The whole compute pipeline freezes while a finished sample is held.
	assign adv      = ~(out_valid & out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && in_cnt_q == ELEM_LAST) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (adv && iss_cnt_q == '1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!ctl_s1.valid && !mac_busy) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			iss_cnt_q <= '0;
		end else begin
			if (in_acc) begin
				in_cnt_q <= in_cnt_q + 1'b1;
			end
			if (state_q == ST_RUN && adv) begin
				iss_cnt_q <= iss_cnt_q + 1'b1;
			end
		end
	end

	assign dq = DQ_W'(level) * DQ_W'($signed({1'b0, LUM_QUANT[in_cnt_q]}));

	// One tap per cycle while adv; the counter walks the row then the column pass.
	always_comb begin
		iss_tap       = iss_cnt_q[TAP_W-1:0];
		iss_ctl.valid = (state_q == ST_RUN);
		iss_ctl.first = (iss_tap == '0);
		iss_ctl.last  = (iss_tap == TAP_LAST);
		iss_ctl.pass  = pass_t'(iss_cnt_q[ISSUE_W-1]);
		iss_ctl.elem  = iss_cnt_q[ISSUE_W-2:TAP_W];
		coef_raddr    = {iss_ctl.elem[ELEM_W-1:TAP_W], iss_tap};
		row_raddr     = {iss_tap, iss_ctl.elem[TAP_W-1:0]};
		coef_re       = adv & iss_ctl.valid & (iss_ctl.pass == PASS_ROW);
		row_re        = adv & iss_ctl.valid & (iss_ctl.pass == PASS_COL);
		cos_u         = iss_tap;
		if (iss_ctl.pass == PASS_ROW) begin
			cos_x = iss_ctl.elem[TAP_W-1:0];
		end else begin
			cos_x = iss_ctl.elem[ELEM_W-1:TAP_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= iss_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_s1 <= C_W'(cos_q(cos_u, cos_x, COS_FRAC_BITS));
		end
	end

	assign a_s1 = (ctl_s1.pass == PASS_ROW) ?
		{{(ROW_W - DQ_W){coef_rd[DQ_W-1]}}, coef_rd} : row_rd;

	dqidct_ram #(
		.WIDTH (DQ_W),
		.DEPTH (NCOEF)
	) u_coef_ram (
		.clk   (clk),
		.we    (in_acc),
		.waddr (in_cnt_q),
		.wdata (dq),
		.re    (coef_re),
		.raddr (coef_raddr),
		.rdata (coef_rd)
	);

	assign row_we = adv & done.valid & (done.pass == PASS_ROW);

	dqidct_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NCOEF)
	) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (done.elem),
		.wdata (row_val),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rd)
	);

	dqidct_mac #(
		.COS_FRAC_BITS (COS_FRAC_BITS)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_s1  (ctl_s1),
		.a_s1    (a_s1),
		.c_s1    (cos_s1),
		.done    (done),
		.busy    (mac_busy),
		.row_val (row_val),
		.col_val (col_val)
	);

	assign out_load = adv & done.valid & (done.pass == PASS_COL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample        <= col_val;
			last_of_block <= (done.elem == ELEM_LAST);
		end
	end

endmodule

// ===== tb/sv/dqidct_sample_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqidct_sample_checker
// Watches both channels of the dequantizing 8x8 IDCT, gathers the levels of
// each block, computes the 64 expected samples in fixed point and compares
// every sample the block delivers against them in order.
// ----------------------------------------------------------------------------
module dqidct_sample_checker
	import dqidct_pkg::*;
#(
	parameter int COS_FRAC_BITS = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic signed [LEVEL_W-1:0]  level,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       last_of_block,
	output int                         fail_count,
	output int                         pending,
	output int                         samples_checked
);

	localparam int ROW_SHIFT = COS_FRAC_BITS - ROW_FRAC;
	localparam int COL_SHIFT = COS_FRAC_BITS + ROW_FRAC - 2;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic                       last;
	} idct_sample_t;

	// basis[u][x] is the DCT basis entry rounded to COS_FRAC_BITS fraction bits.
	longint                    basis [BLOCK_SIZE][BLOCK_SIZE];
	logic signed [LEVEL_W-1:0] block_levels [NCOEF];
	int                        level_index = 0;
	idct_sample_t              expected_samples [$];
	int                        mismatches = 0;
	int                        outstanding = 0;
	int                        checked = 0;

	assign fail_count      = mismatches;
	assign pending         = outstanding;
	assign samples_checked = checked;

	initial begin : build_basis
		int     u;
		int     x;
		int     a;
		bit     neg;
		longint mag;
		for (u = 0; u < BLOCK_SIZE; u++) begin
			for (x = 0; x < BLOCK_SIZE; x++) begin
				neg = 1'b0;
				if (u == 0) begin
					a = BLOCK_SIZE / 2;
				end else begin
					// Fold the angle u*(2x+1)*pi/16 into the first quadrant.
					a = (u * (2 * x + 1)) % (4 * BLOCK_SIZE);
					if (a > 2 * BLOCK_SIZE)
						a = 4 * BLOCK_SIZE - a;
					if (a > BLOCK_SIZE) begin
						a = 2 * BLOCK_SIZE - a;
						neg = 1'b1;
					end
				end
				mag = (longint'(HALF_COS_Q30[a]) + (longint'(1) << (29 - COS_FRAC_BITS)))
					>> (30 - COS_FRAC_BITS);
				basis[u][x] = neg ? -mag : mag;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : track
		int           u;
		int           v;
		int           x;
		int           y;
		longint       acc;
		longint       rounded;
		int           row_pass [NCOEF];
		idct_sample_t want;
		if (!arst_n) begin
			level_index = 0;
			expected_samples.delete();
		end else begin
			if (in_valid && !in_stall) begin
				block_levels[level_index] = level;
				if (level_index == NCOEF - 1) begin
					level_index = 0;
					// Row pass on the dequantized levels, kept with ROW_FRAC fraction bits.
					for (u = 0; u < BLOCK_SIZE; u++) begin
						for (y = 0; y < BLOCK_SIZE; y++) begin
							acc = 0;
							for (v = 0; v < BLOCK_SIZE; v++)
								acc += longint'(block_levels[u * BLOCK_SIZE + v])
									* longint'(LUM_QUANT[u * BLOCK_SIZE + v]) * basis[v][y];
							row_pass[u * BLOCK_SIZE + y] =
								int'((acc + (longint'(1) <<< (ROW_SHIFT - 1))) >>> ROW_SHIFT);
						end
					end
					// Column pass; the shift folds in the factor of four.
					for (x = 0; x < BLOCK_SIZE; x++) begin
						for (y = 0; y < BLOCK_SIZE; y++) begin
							acc = 0;
							for (u = 0; u < BLOCK_SIZE; u++)
								acc += basis[u][x] * longint'(row_pass[u * BLOCK_SIZE + y]);
							rounded = (acc + (longint'(1) <<< (COL_SHIFT - 1))) >>> COL_SHIFT;
							if (rounded > 32767)
								rounded = 32767;
							if (rounded < -32768)
								rounded = -32768;
							want.value = SAMPLE_W'(rounded);
							want.last  = (x == BLOCK_SIZE - 1) && (y == BLOCK_SIZE - 1);
							expected_samples.push_back(want);
						end
					end
				end else begin
					level_index++;
				end
			end
			if (out_valid && !out_stall) begin
				checked++;
				if (expected_samples.size() == 0) begin
					mismatches++;
					$error("sample: expected none, actual %0d", sample);
				end else begin
					want = expected_samples.pop_front();
					if (sample !== want.value) begin
						mismatches++;
						$error("sample: expected %0d, actual %0d", want.value, sample);
					end
					if (last_of_block !== want.last) begin
						mismatches++;
						$error("last_of_block: expected %0b, actual %0b", want.last,
							last_of_block);
					end
				end
			end
		end
		outstanding = expected_samples.size();
	end

endmodule

// ===== tb/sv/dequantize_inverse_dct_8x8_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dequantize_inverse_dct_8x8_test
// Feeds blocks of quantized levels into the dequantizing 8x8 IDCT with random
// gaps on the request side and random stalls on the sample side, while a
// checker beside the block predicts and compares every sample.
// ----------------------------------------------------------------------------
module dequantize_inverse_dct_8x8_test;
	import dqidct_pkg::*;

	localparam int COS_FRAC_BITS = 14;

	typedef enum int {
		BLK_UNIFORM,
		BLK_NATURAL,
		BLK_SPARSE,
		BLK_PEAK,
		BLK_EDGE_HIGH,
		BLK_ALL_MIN
	} block_style_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [LEVEL_W-1:0]  level;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_of_block;

	int fail_count;
	int pending;
	int samples_checked;
	int levels_sent = 0;
	int out_hold = 0;
	bit in_quiet = 1'b0;
	bit out_quiet = 1'b0;

	always #10 clk = ~clk;

	dequantize_inverse_dct_8x8 #(
		.COS_FRAC_BITS(COS_FRAC_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.level        (level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample       (sample),
		.last_of_block(last_of_block)
	);

	dqidct_sample_checker #(
		.COS_FRAC_BITS(COS_FRAC_BITS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.level          (level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.sample         (sample),
		.last_of_block  (last_of_block),
		.fail_count     (fail_count),
		.pending        (pending),
		.samples_checked(samples_checked)
	);

	initial begin
		#2_000_000;
		$display("dequantize_inverse_dct_8x8_test failed");
		$finish;
	end

	// After each accepted sample the receiver picks how long to hold off the next.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if ($urandom_range(0, 31) == 0)
				out_quiet = !out_quiet;
			out_hold = out_quiet ? 0 : $urandom_range(0, 10);
		end
	end

	always @(negedge clk) begin
		out_stall <= (out_hold != 0);
		if (out_hold != 0)
			out_hold--;
	end

	task automatic push_level(input int value);
		int gap;
		if ($urandom_range(0, 31) == 0)
			in_quiet = !in_quiet;
		gap = in_quiet ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
			level    <= LEVEL_W'($urandom);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		level    <= LEVEL_W'(value);
		do @(posedge clk); while (in_stall);
		levels_sent++;
	endtask

	task automatic push_block(input block_style_t style, input int count);
		int p;
		int r;
		int c;
		int value;
		int px;
		int py;
		int ar;
		int ac;
		bit pos_r;
		bit pos_c;
		bit flip;
		int specials [7] = '{2047, -2048, 0, -1, 1, 1365, -1366};
		px   = $urandom_range(0, BLOCK_SIZE - 1);
		py   = $urandom_range(0, BLOCK_SIZE - 1);
		flip = $urandom_range(0, 1);
		for (p = 0; p < count; p++) begin
			r = p / BLOCK_SIZE;
			c = p % BLOCK_SIZE;
			case (style)
				BLK_UNIFORM: begin
					value = $urandom_range(0, 4095) - 2048;
				end
				BLK_NATURAL: begin
					// Energy falls off away from the DC term, as in real images.
					if (p == 0)
						value = $urandom_range(0, 2047) - 1024;
					else if ($urandom_range(0, r + c) == 0)
						value = $urandom_range(0, 64) - 32;
					else
						value = 0;
				end
				BLK_SPARSE: begin
					value = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) - 2048 : 0;
				end
				BLK_PEAK: begin
					// Match the signs of the basis at one output position to drive it
					// into saturation.
					ar    = (r * (2 * px + 1)) % (4 * BLOCK_SIZE);
					ac    = (c * (2 * py + 1)) % (4 * BLOCK_SIZE);
					pos_r = (r == 0) || (ar < BLOCK_SIZE) || (ar > 3 * BLOCK_SIZE);
					pos_c = (c == 0) || (ac < BLOCK_SIZE) || (ac > 3 * BLOCK_SIZE);
					value = ((pos_r == pos_c) ^ flip) ? 2047 : -2048;
				end
				BLK_EDGE_HIGH: begin
					value = (p < 7) ? specials[p] : 2047;
				end
				default: begin
					value = -2048;
				end
			endcase
			push_level(value);
		end
	endtask

	initial begin
		int tail;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		level     = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Extreme levels, then blocks that saturate high and low.
		push_block(BLK_EDGE_HIGH, NCOEF);
		push_block(BLK_ALL_MIN, NCOEF);

		push_block(block_style_t'($urandom_range(BLK_UNIFORM, BLK_PEAK)), NCOEF);
		// A partial block stays buffered and never produces samples.
		tail = $urandom_range(1, 8);
		push_block(block_style_t'($urandom_range(BLK_UNIFORM, BLK_PEAK)), tail);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (1200) @(negedge clk);

		$display("Sent %0d levels: %0d full blocks and %0d levels of an unfinished block.",
			levels_sent, levels_sent / NCOEF, levels_sent % NCOEF);
		$display("Checked %0d samples with %0d mismatches.", samples_checked, fail_count);
		if (fail_count == 0) begin
			$display("dequantize_inverse_dct_8x8_test passed");
		end else begin
			$display("dequantize_inverse_dct_8x8_test failed");
		end
		$finish;
	end

endmodule
